// ===== hdl/ftpm_pkg.sv =====
// Shared types and constants for the folded text pattern matcher.
`default_nettype none

package ftpm_pkg;

    // Default pattern capacity in bytes.
    localparam int PATTERN_MAX_DEFAULT = 256;

    // Command codes carried on the command channel.
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_BEGIN  = 2'd2,
        OP_TEXT   = 2'd3
    } opcode_t;

    // One command transfer.
    typedef struct packed {
        opcode_t     opcode;
        logic [7:0]  data_byte;
        logic [15:0] message_id;
        logic [15:0] source_start;
        logic [15:0] source_end;
    } cmd_t;

    // One match report transfer.
    typedef struct packed {
        logic [15:0] match_message;
        logic [15:0] match_start;
        logic [15:0] match_end;
    } hit_t;

endpackage : ftpm_pkg

`default_nettype wire

// ===== hdl/ftpm_table.sv =====
// Pattern and failure table memory of the matcher, one synchronous read port.
`default_nettype none

module ftpm_table #(
    parameter int PATTERN_MAX = ftpm_pkg::PATTERN_MAX_DEFAULT,
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   wr_pat_en,
    input  wire logic                   wr_fail_en,
    input  wire logic [IDX_W-1:0]       wr_addr,
    input  wire logic [7:0]             wr_pat,
    input  wire logic [IDX_W-1:0]       wr_fail,
    input  wire logic [IDX_W-1:0]       rd_addr,
    output logic      [7:0]             rd_pat,
    output logic      [IDX_W-1:0]       rd_fail
);

    // Entry i holds pattern byte i and the failure value of position i-1,
    // so a single read gives both values that one step of the walk needs.
    typedef struct packed {
        logic [7:0]       pat;
        logic [IDX_W-1:0] fail;
    } entry_t;

    entry_t mem [PATTERN_MAX];
    entry_t rd_q_reg;

    // Field-wise write; the two fields are never written in the same cycle.
    always_ff @(posedge clk)
    begin
        if (wr_pat_en)
        begin
            mem[wr_addr].pat <= wr_pat;
        end
        if (wr_fail_en)
        begin
            mem[wr_addr].fail <= wr_fail;
        end
    end

    // Registered read.
    always_ff @(posedge clk)
    begin
        rd_q_reg <= mem[rd_addr];
    end

    assign rd_pat  = rd_q_reg.pat;
    assign rd_fail = rd_q_reg.fail;

endmodule : ftpm_table

`default_nettype wire

// ===== hdl/folded_text_pattern_matcher_core.sv =====
// Top level of the folded text pattern matcher: control, state and start-offset ring.
//
// Commands arrive on cmd (cmd_valid, cmd_stall); a transfer completes on a
// rising edge with cmd_valid high and cmd_stall low. Match reports leave on
// hit (hit_valid, hit_stall) under the same rule.
// Clear, begin-message, overflowing appends, failed-query and skipped text
// bytes are handled in the idle state. Any other append or live text byte
// also walks the failure chain: every step is one read of the pattern
// table memory, whose single read port sets the pace. A step only undoes
// an earlier advance of the state, so over a text the steps never
// outnumber the live bytes. A match report is registered after the final
// compare. The next command is taken while a report still waits; if a
// further match is found while hit_stall holds the previous report, the
// block waits until that report has been transferred.
// Reset clears the pattern length, match and build state, skip bound,
// message number and query failure flag. The table and ring memories hold
// no reset value and need no clearing pass; only written entries are used.
`default_nettype none

module folded_text_pattern_matcher_core #(
    parameter int PATTERN_MAX = ftpm_pkg::PATTERN_MAX_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_stall,
    input  wire ftpm_pkg::cmd_t cmd,
    output logic                hit_valid,
    input  wire logic           hit_stall,
    output ftpm_pkg::hit_t      hit
);

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int SUM_W = LEN_W + 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    ftpm_pkg::cmd_t     item_reg, item_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [IDX_W-1:0]   build_reg, build_next;
    logic [IDX_W-1:0]   match_reg, match_next;
    logic [15:0]        skip_reg, skip_next;
    logic [IDX_W-1:0]   ring_idx_reg, ring_idx_next;
    logic [15:0]        msg_reg, msg_next;
    logic               failed_reg, failed_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic               fwd_reg, fwd_next;
    logic               out_valid_reg, out_valid_next;
    ftpm_pkg::hit_t     out_item_reg, out_item_next;

    logic               accept;
    logic               text_live;
    logic               out_free;
    logic [SUM_W-1:0]   first_sum;
    logic [IDX_W-1:0]   first_idx;
    logic [7:0]         rd_pat;
    logic [IDX_W-1:0]   rd_fail;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_pat_en;
    logic               wr_fail_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               byte_eq;
    logic               walk_step;
    logic [LEN_W-1:0]   walk_res;
    ftpm_pkg::hit_t     hit_payload;

    // Start-offset ring memory.
    logic [15:0]        ring_mem [PATTERN_MAX];
    logic [15:0]        ring_q_reg;
    logic               ring_en;

    // Pattern and failure table.
    ftpm_table #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_table (
        .clk        (clk),
        .wr_pat_en  (wr_pat_en),
        .wr_fail_en (wr_fail_en),
        .wr_addr    (wr_addr),
        .wr_pat     (item_next.data_byte),
        .wr_fail    (walk_res[IDX_W-1:0]),
        .rd_addr    (rd_addr),
        .rd_pat     (rd_pat),
        .rd_fail    (rd_fail)
    );

    // Handshake status.
    assign accept    = cmd_valid && (state_reg == S_IDLE);
    assign cmd_stall = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !hit_stall;
    assign hit_valid = out_valid_reg;
    assign hit       = out_item_reg;

    // A text byte is searched only with a usable query and outside the skip region.
    assign text_live = !failed_reg && (len_reg != '0) && (cmd.source_start >= skip_reg);

    // Ring slot that holds the start of the first byte of a possible match.
    always_comb
    begin
        first_sum = SUM_W'(ring_idx_reg) + SUM_W'(PATTERN_MAX) - SUM_W'(len_reg) + SUM_W'(1);
        if (first_sum >= SUM_W'(PATTERN_MAX))
        begin
            first_sum = first_sum - SUM_W'(PATTERN_MAX);
        end
        first_idx = first_sum[IDX_W-1:0];
    end

    assign ring_en = accept && (cmd.opcode == ftpm_pkg::OP_TEXT) && text_live;

    // Ring write of the current start and read of the first start in the same cycle.
    always_ff @(posedge clk)
    begin
        if (ring_en)
        begin
            ring_mem[ring_idx_reg] <= cmd.source_start;
            ring_q_reg             <= ring_mem[first_idx];
        end
    end

    // One step of the failure walk on the data read in the previous cycle.
    assign byte_eq   = (item_reg.data_byte == rd_pat);
    assign walk_step = !byte_eq && (cur_reg != '0);

    always_comb
    begin
        walk_res = LEN_W'(cur_reg) + LEN_W'(byte_eq);
        if ((item_reg.opcode == ftpm_pkg::OP_APPEND) && (pos_reg == '0))
        begin
            walk_res = '0;
        end
    end

    // Report payload; a one-byte pattern takes its start from the held command.
    always_comb
    begin
        hit_payload.match_message = msg_reg;
        hit_payload.match_start   = fwd_reg ? item_reg.source_start : ring_q_reg;
        hit_payload.match_end     = item_reg.source_end;
    end

    // Table addressing.
    always_comb
    begin
        if (state_reg == S_WALK)
        begin
            rd_addr = rd_fail;
        end
        else if (cmd.opcode == ftpm_pkg::OP_APPEND)
        begin
            rd_addr = build_reg;
        end
        else
        begin
            rd_addr = match_reg;
        end
        wr_pat_en  = accept && (cmd.opcode == ftpm_pkg::OP_APPEND)
                     && (len_reg < LEN_W'(PATTERN_MAX));
        wr_fail_en = (state_reg == S_WALK) && !walk_step
                     && (item_reg.opcode == ftpm_pkg::OP_APPEND)
                     && (pos_reg != IDX_W'(PATTERN_MAX - 1));
        wr_addr    = (state_reg == S_WALK) ? (pos_reg + IDX_W'(1)) : len_reg[IDX_W-1:0];
    end

    // Sequencer and state updates.
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        len_next       = len_reg;
        build_next     = build_reg;
        match_next     = match_reg;
        skip_next      = skip_reg;
        ring_idx_next  = ring_idx_reg;
        msg_next       = msg_reg;
        failed_next    = failed_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        fwd_next       = fwd_reg;
        out_valid_next = out_valid_reg && hit_stall;
        out_item_next  = out_item_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next = cmd;
                    case (cmd.opcode)
                        ftpm_pkg::OP_CLEAR:
                        begin
                            len_next    = '0;
                            build_next  = '0;
                            match_next  = '0;
                            failed_next = 1'b0;
                        end
                        ftpm_pkg::OP_APPEND:
                        begin
                            if (len_reg < LEN_W'(PATTERN_MAX))
                            begin
                                pos_next   = len_reg[IDX_W-1:0];
                                len_next   = len_reg + LEN_W'(1);
                                cur_next   = build_reg;
                                state_next = S_WALK;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        ftpm_pkg::OP_BEGIN:
                        begin
                            match_next = '0;
                            skip_next  = '0;
                            msg_next   = cmd.message_id;
                        end
                        ftpm_pkg::OP_TEXT:
                        begin
                            if (text_live)
                            begin
                                cur_next   = match_reg;
                                fwd_next   = (first_idx == ring_idx_reg);
                                state_next = S_WALK;
                                if (ring_idx_reg == IDX_W'(PATTERN_MAX - 1))
                                begin
                                    ring_idx_next = '0;
                                end
                                else
                                begin
                                    ring_idx_next = ring_idx_reg + IDX_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                if (walk_step)
                begin
                    cur_next = rd_fail;
                end
                else if (item_reg.opcode == ftpm_pkg::OP_APPEND)
                begin
                    build_next = walk_res[IDX_W-1:0];
                    state_next = S_IDLE;
                end
                else if (walk_res == len_reg)
                begin
                    match_next = '0;
                    skip_next  = item_reg.source_end;
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_item_next  = hit_payload;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    match_next = walk_res[IDX_W-1:0];
                    state_next = S_IDLE;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = hit_payload;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            build_reg     <= '0;
            match_reg     <= '0;
            skip_reg      <= '0;
            ring_idx_reg  <= '0;
            msg_reg       <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            build_reg     <= build_next;
            match_reg     <= match_next;
            skip_reg      <= skip_next;
            ring_idx_reg  <= ring_idx_next;
            msg_reg       <= msg_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and walk registers.
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        cur_reg      <= cur_next;
        pos_reg      <= pos_next;
        fwd_reg      <= fwd_next;
        out_item_reg <= out_item_next;
    end

    // The match state always points inside the current pattern.
    assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != '0) |-> (LEN_W'(match_reg) < len_reg))
        else $error("match state reached the pattern length");

    // The build state stays below the pattern length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != '0) |-> (LEN_W'(build_reg) < len_reg))
        else $error("build state reached the pattern length");

    // A pending report only waits behind a held report.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> out_valid_reg)
        else $error("report held back with a free output register");

    // The walk only runs for appends and text bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |->
        ((item_reg.opcode == ftpm_pkg::OP_APPEND) || (item_reg.opcode == ftpm_pkg::OP_TEXT)))
        else $error("failure walk started for a command without one");

    // The ring pointer wraps at the pattern capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        ring_idx_reg <= IDX_W'(PATTERN_MAX - 1))
        else $error("ring pointer beyond the ring depth");

endmodule : folded_text_pattern_matcher_core

`default_nettype wire

// ===== tb/sv/folded_text_pattern_matcher_core_test.sv =====
// Self-checking bench of the folded text pattern matcher: directed table, hold-off, random traffic.
module folded_text_pattern_matcher_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PMAX       = ftpm_pkg::PATTERN_MAX_DEFAULT;
    localparam int RAND_ITEMS = 1400;
    localparam int HOLD_LEN   = 300;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    ftpm_pkg::cmd_t cmd_bus;
    logic hit_valid;
    logic hit_stall;
    ftpm_pkg::hit_t hit_bus;

    folded_text_pattern_matcher_core #(.PATTERN_MAX(PMAX)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd_bus),
        .hit_valid (hit_valid),
        .hit_stall (hit_stall),
        .hit       (hit_bus)
    );

    // Own copy of the matcher state, used to predict match reports.
    logic [7:0]  kmp_pattern [PMAX];
    int          kmp_failure [PMAX];
    logic [15:0] kmp_starts  [PMAX];
    int          kmp_len;
    int          kmp_build;
    int          kmp_state;
    logic [15:0] kmp_skip;
    int          kmp_ring_pos;
    logic [15:0] kmp_message;
    bit          kmp_failed;

    // Match reports still to come, oldest first.
    ftpm_pkg::hit_t pending_hits [$];

    int fault_count;
    int items_sent;
    int send_pct;
    int recv_pct;
    int hold_asked;
    int hold_served;
    int hold_left;

    // Stimulus helpers: the query being searched for and the running text offset.
    logic [7:0]  query_bytes [$];
    logic [7:0]  alphabet [3];
    logic [15:0] off_now;
    logic [15:0] char_s;
    logic [15:0] char_e;

    // One row of the directed table.
    typedef struct {
        ftpm_pkg::cmd_t c;
        bit             fixed;
        bit             want_hit;
        ftpm_pkg::hit_t want;
    } row_t;

    row_t directed [$];

    // Advance the predicted state by one command transfer.
    task automatic kmp_track(input ftpm_pkg::cmd_t c, output bit fires,
                             output ftpm_pkg::hit_t h);
        int k;
        int first;
        fires = 1'b0;
        h     = '0;
        case (c.opcode)
            ftpm_pkg::OP_CLEAR:
            begin
                kmp_len    = 0;
                kmp_build  = 0;
                kmp_state  = 0;
                kmp_failed = 1'b0;
            end
            ftpm_pkg::OP_APPEND:
            begin
                if (kmp_len >= PMAX)
                begin
                    kmp_failed = 1'b1;
                end
                else
                begin
                    kmp_pattern[kmp_len] = c.data_byte;
                    if (kmp_len == 0)
                    begin
                        kmp_failure[0] = 0;
                        kmp_build      = 0;
                    end
                    else
                    begin
                        k = kmp_build;
                        while (k != 0 && c.data_byte != kmp_pattern[k])
                            k = kmp_failure[k - 1];
                        if (c.data_byte == kmp_pattern[k])
                            k++;
                        kmp_failure[kmp_len] = k;
                        kmp_build            = k;
                    end
                    kmp_len++;
                end
            end
            ftpm_pkg::OP_BEGIN:
            begin
                kmp_state   = 0;
                kmp_skip    = '0;
                kmp_message = c.message_id;
            end
            default:
            begin
                if (!kmp_failed && kmp_len != 0 && c.source_start >= kmp_skip)
                begin
                    kmp_starts[kmp_ring_pos] = c.source_start;
                    first        = (kmp_ring_pos + PMAX - (kmp_len - 1)) % PMAX;
                    kmp_ring_pos = (kmp_ring_pos + 1) % PMAX;
                    k = kmp_state;
                    while (k != 0 && c.data_byte != kmp_pattern[k])
                        k = kmp_failure[k - 1];
                    if (c.data_byte == kmp_pattern[k])
                        k++;
                    if (k != kmp_len)
                    begin
                        kmp_state = k;
                    end
                    else
                    begin
                        kmp_state       = 0;
                        kmp_skip        = c.source_end;
                        fires           = 1'b1;
                        h.match_message = kmp_message;
                        h.match_start   = kmp_starts[first];
                        h.match_end     = c.source_end;
                    end
                end
            end
        endcase
    endtask

    // Offer one command, wait for its transfer and record what it should cause.
    task automatic send_cmd(input ftpm_pkg::cmd_t c, input bit fixed = 1'b0,
                            input bit want_hit = 1'b0, input ftpm_pkg::hit_t want = '0);
        bit             fires;
        ftpm_pkg::hit_t h;
        while ($urandom_range(0, 99) < send_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_bus   <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        kmp_track(c, fires, h);
        if (fixed)
        begin
            fires = want_hit;
            h     = want;
        end
        if (fires)
            pending_hits.push_back(h);
        items_sent++;
        @(negedge clk);
    endtask

    // A command with every field random; callers overwrite the fields that matter.
    function automatic ftpm_pkg::cmd_t noise_cmd();
        ftpm_pkg::cmd_t c;
        c.opcode       = ftpm_pkg::opcode_t'($urandom_range(0, 3));
        c.data_byte    = 8'($urandom_range(0, 255));
        c.message_id   = 16'($urandom_range(0, 65535));
        c.source_start = 16'($urandom_range(0, 65535));
        c.source_end   = 16'($urandom_range(0, 65535));
        return c;
    endfunction

    task automatic add_row(input ftpm_pkg::opcode_t op, input logic [7:0] b,
                           input logic [15:0] id, input logic [15:0] s,
                           input logic [15:0] e, input bit fixed = 1'b0,
                           input bit want_hit = 1'b0, input logic [15:0] wm = '0,
                           input logic [15:0] ws = '0, input logic [15:0] we = '0);
        row_t r;
        r.c.opcode             = op;
        r.c.data_byte          = b;
        r.c.message_id         = id;
        r.c.source_start       = s;
        r.c.source_end         = e;
        r.fixed                = fixed;
        r.want_hit             = want_hit;
        r.want.match_message   = wm;
        r.want.match_start     = ws;
        r.want.match_end       = we;
        directed.push_back(r);
    endtask

    task automatic send_append(input logic [7:0] b);
        ftpm_pkg::cmd_t c;
        c           = noise_cmd();
        c.opcode    = ftpm_pkg::OP_APPEND;
        c.data_byte = b;
        send_cmd(c);
        query_bytes.push_back(b);
    endtask

    task automatic send_clear();
        ftpm_pkg::cmd_t c;
        c        = noise_cmd();
        c.opcode = ftpm_pkg::OP_CLEAR;
        send_cmd(c);
        query_bytes.delete();
    endtask

    task automatic send_begin();
        ftpm_pkg::cmd_t c;
        c        = noise_cmd();
        c.opcode = ftpm_pkg::OP_BEGIN;
        send_cmd(c);
        if ($urandom_range(0, 9) == 0)
            off_now = 16'($urandom_range(0, 65535));
        else
            off_now = 16'($urandom_range(0, 1000));
        char_s = off_now;
        char_e = off_now;
    endtask

    // One text byte; several bytes may share a source character, and the
    // offset now and then steps back so that skipped bytes occur.
    task automatic send_text(input logic [7:0] b);
        ftpm_pkg::cmd_t c;
        if ($urandom_range(0, 32) == 0)
            off_now = off_now - 16'($urandom_range(1, 16));
        if (char_s == char_e || $urandom_range(0, 4) != 0)
        begin
            char_s  = off_now;
            char_e  = off_now + 16'($urandom_range(1, 4));
            off_now = char_e;
        end
        c              = noise_cmd();
        c.opcode       = ftpm_pkg::OP_TEXT;
        c.data_byte    = b;
        c.source_start = char_s;
        c.source_end   = char_e;
        send_cmd(c);
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 99) < 85)
            return alphabet[$urandom_range(0, 2)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic new_alphabet();
        for (int i = 0; i < 3; i++)
            alphabet[i] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0)
            alphabet[1] = alphabet[0];
    endtask

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, plus one long hold-off when asked.
    initial
    begin
        hit_stall   = 1'b0;
        hold_served = 0;
        hold_left   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_asked)
            begin
                hold_served = hold_asked;
                hold_left   = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hit_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                hit_stall <= ($urandom_range(0, 99) < recv_pct);
            end
        end
    end

    // Compare each report transfer with the oldest expectation.
    always @(posedge clk)
    begin
        ftpm_pkg::hit_t want;
        if (rst_n && hit_valid && !hit_stall)
        begin
            if (pending_hits.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected report: message %h start %h end %h",
                             hit_bus.match_message, hit_bus.match_start, hit_bus.match_end);
            end
            else
            begin
                want = pending_hits.pop_front();
                if (hit_bus.match_message != want.match_message ||
                    hit_bus.match_start != want.match_start ||
                    hit_bus.match_end != want.match_end)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("report mismatch: expected %h/%h/%h, got %h/%h/%h",
                                 want.match_message, want.match_start, want.match_end,
                                 hit_bus.match_message, hit_bus.match_start,
                                 hit_bus.match_end);
                end
            end
        end
    end

    // Overall time limit.
    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    // Main sequence.
    initial
    begin
        int             rand_start;
        int             pick;
        ftpm_pkg::cmd_t c;
        logic [7:0]     b;
        bit             long_done;

        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        cmd_bus      = '0;
        send_pct     = 0;
        recv_pct     = 0;
        hold_asked   = 0;
        fault_count  = 0;
        items_sent   = 0;
        long_done    = 1'b0;
        kmp_len      = 0;
        kmp_build    = 0;
        kmp_state    = 0;
        kmp_skip     = '0;
        kmp_ring_pos = 0;
        kmp_message  = '0;
        kmp_failed   = 1'b0;
        off_now      = '0;
        char_s       = '0;
        char_e       = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table: empty query, field extremes, skipping, append during
        // a message, no overlapping matches, clear, and a failure-chain walk.
        add_row(ftpm_pkg::OP_TEXT,   8'h41, 16'h0000, 16'h0000, 16'h0001, 1'b1);
        add_row(ftpm_pkg::OP_BEGIN,  8'h00, 16'hFFFF, 16'h0000, 16'h0000);
        add_row(ftpm_pkg::OP_APPEND, 8'h00, 16'h0000, 16'h0000, 16'h0000);
        add_row(ftpm_pkg::OP_APPEND, 8'hFF, 16'h0000, 16'h0000, 16'h0000);
        add_row(ftpm_pkg::OP_TEXT,   8'h00, 16'h0000, 16'h0000, 16'h0001);
        add_row(ftpm_pkg::OP_TEXT,   8'hFF, 16'h0000, 16'h0001, 16'hFFFF, 1'b1, 1'b1,
                16'hFFFF, 16'h0000, 16'hFFFF);
        add_row(ftpm_pkg::OP_TEXT,   8'hFF, 16'h0000, 16'hFFFE, 16'hFFFF, 1'b1);
        add_row(ftpm_pkg::OP_TEXT,   8'h00, 16'h0000, 16'hFFFF, 16'hFFFF);
        add_row(ftpm_pkg::OP_BEGIN,  8'hFF, 16'h0000, 16'hFFFF, 16'hFFFF);
        add_row(ftpm_pkg::OP_APPEND, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_row(ftpm_pkg::OP_TEXT,   8'h00, 16'h0000, 16'h0002, 16'h0003);
        add_row(ftpm_pkg::OP_TEXT,   8'hFF, 16'h0000, 16'h0003, 16'h0005);
        add_row(ftpm_pkg::OP_TEXT,   8'h00, 16'h0000, 16'h0005, 16'h0006);
        add_row(ftpm_pkg::OP_TEXT,   8'hFF, 16'h0000, 16'h0006, 16'h0007);
        add_row(ftpm_pkg::OP_TEXT,   8'h00, 16'h0000, 16'h0007, 16'h0008);
        add_row(ftpm_pkg::OP_CLEAR,  8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_row(ftpm_pkg::OP_TEXT,   8'h00, 16'h0000, 16'h0009, 16'h000A, 1'b1);
        add_row(ftpm_pkg::OP_APPEND, 8'hAA, 16'h0000, 16'h0000, 16'h0000);
        add_row(ftpm_pkg::OP_APPEND, 8'hAA, 16'h0000, 16'h0000, 16'h0000);
        add_row(ftpm_pkg::OP_TEXT,   8'hAA, 16'h0000, 16'h000A, 16'h000B);
        add_row(ftpm_pkg::OP_APPEND, 8'h55, 16'h0000, 16'h0000, 16'h0000);
        add_row(ftpm_pkg::OP_TEXT,   8'hAA, 16'h0000, 16'h000B, 16'h000C);
        add_row(ftpm_pkg::OP_TEXT,   8'hAA, 16'h0000, 16'h000C, 16'h000D);
        add_row(ftpm_pkg::OP_TEXT,   8'h55, 16'h0000, 16'h000D, 16'h000F);
        add_row(ftpm_pkg::OP_TEXT,   8'h55, 16'h0000, 16'h000D, 16'h000F);
        foreach (directed[i])
            send_cmd(directed[i].c, directed[i].fixed, directed[i].want_hit, directed[i].want);

        // Long receiver hold-off with a one-byte query, so that matches pile up
        // and the command side backs up.
        send_clear();
        send_append(8'h5A);
        send_begin();
        hold_asked++;
        repeat (40)
            send_text(8'h5A);

        // Random traffic in three idling phases.
        new_alphabet();
        rand_start = items_sent;
        while (items_sent - rand_start < RAND_ITEMS)
        begin
            if (items_sent - rand_start < RAND_ITEMS / 3)
            begin
                send_pct = 7;
                recv_pct = 58;
            end
            else if (items_sent - rand_start < 2 * RAND_ITEMS / 3)
            begin
                send_pct = 58;
                recv_pct = 7;
            end
            else
            begin
                send_pct = 0;
                recv_pct = 0;
            end

            pick = $urandom_range(0, 99);
            if (!long_done && items_sent - rand_start > RAND_ITEMS / 2)
            begin
                // Full-capacity query, a match across the ring wrap, then overflow.
                long_done = 1'b1;
                new_alphabet();
                send_clear();
                for (int i = 0; i < PMAX; i++)
                    send_append((i == PMAX - 1) ? ~alphabet[0] : alphabet[0]);
                send_begin();
                for (int i = 0; i < PMAX; i++)
                    send_text(query_bytes[i]);
                send_text(alphabet[0]);
                send_append(alphabet[1]);
                repeat (4)
                    send_text(alphabet[0]);
                send_clear();
            end
            else if (pick < 10 || query_bytes.size() == 0)
            begin
                // Fresh short query.
                new_alphabet();
                send_clear();
                repeat ($urandom_range(1, 6))
                    send_append(alphabet[$urandom_range(0, 2)]);
            end
            else if (pick < 13)
            begin
                send_append(pick_byte());
            end
            else if (pick < 18)
            begin
                repeat ($urandom_range(1, 5))
                begin
                    c = noise_cmd();
                    send_cmd(c);
                    if (c.opcode == ftpm_pkg::OP_CLEAR)
                        query_bytes.delete();
                    else if (c.opcode == ftpm_pkg::OP_APPEND)
                        query_bytes.push_back(c.data_byte);
                end
            end
            else
            begin
                // One message: planted copies of the query among filler bytes.
                send_begin();
                repeat ($urandom_range(2, 8))
                begin
                    if ($urandom_range(0, 1) == 0 && query_bytes.size() <= PMAX)
                    begin
                        foreach (query_bytes[i])
                        begin
                            b = query_bytes[i];
                            if ($urandom_range(0, 49) == 0)
                                b = ~b;
                            send_text(b);
                        end
                    end
                    else
                    begin
                        repeat ($urandom_range(1, 3))
                            send_text(pick_byte());
                    end
                end
            end
        end

        // Drain the outstanding reports, then let the block settle.
        cmd_valid <= 1'b0;
        recv_pct = 0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);

        if (fault_count == 0 && pending_hits.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
